// ===== rtl/drs_pkg.sv =====
// shared types and constants of the disk request scheduler
package drs_pkg;

    localparam int BLK_W     = 16;
    localparam int TAG_W     = 8;
    localparam int TOTAL_W   = 32;
    localparam int PEND_W    = 5;
    localparam int DSIZE_W   = 17;
    localparam int POLICY_W  = 2;
    localparam int CFG_IDX_W = 4;
    localparam int STATUS_W  = 2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_ENQUEUED   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd3;

    // policy codes, the unused code acts as fcfs
    localparam logic [POLICY_W-1:0] POL_FCFS  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_SSTF  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_CSCAN = 2'd2;

    // request types
    localparam logic REQ_ENQUEUE  = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE = 4'd1;

    localparam logic [DSIZE_W-1:0] DISK_SIZE_RST = 17'd65536;

    typedef struct packed {
        logic             req_type;
        logic [BLK_W-1:0] block_number;
        logic [TAG_W-1:0] requester_tag;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLK_W-1:0]    served_block;
        logic [TAG_W-1:0]    served_tag;
        logic [BLK_W-1:0]    seek_distance;
        logic [TOTAL_W-1:0]  total_distance;
        logic [PEND_W-1:0]   pending_count;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic enq;
        logic empty;
        logic scan_start;
        logic scan;
        logic pick;
        logic shift;
        logic fin;
        logic load_out;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_dispatch;
        logic count_zero;
        logic scan_done;
        logic shift_done;
    } t_dp_stat;

endpackage

// ===== rtl/drs_ctrl.sv =====
// sequencing state machine of the disk request scheduler
module drs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  drs_pkg::t_dp_stat i_stat,
    output drs_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_FIN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_stat.is_dispatch) begin
                    o_cmd.enq = 1'b1;
                    n_state   = S_DONE;
                end else if (i_stat.count_zero) begin
                    o_cmd.empty = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    o_cmd.pick = 1'b1;
                    n_state    = S_SHIFT;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_SHIFT: begin
                if (i_stat.shift_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.shift = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/drs_dp.sv =====
// queue memory, scan trackers, head and seek total of the disk request scheduler
module drs_dp #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  drs_pkg::t_dp_cmd                 i_cmd,
    output drs_pkg::t_dp_stat                o_stat,
    input  drs_pkg::t_in_item                i_in_item,
    input  logic                             i_cfg_valid,
    input  logic [drs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [drs_pkg::DSIZE_W-1:0]      i_cfg_data,
    output drs_pkg::t_out_item               o_out_item
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BW    = drs_pkg::BLK_W;
    localparam int TW    = drs_pkg::TAG_W;

    // queue storage, arrival order
    logic [BW-1:0] mem_blk [QUEUE_DEPTH];
    logic [TW-1:0] mem_tag [QUEUE_DEPTH];

    logic [CNT_W-1:0]                r_count;
    logic [BW-1:0]                   r_head;
    logic [drs_pkg::TOTAL_W-1:0]     r_total;
    logic [drs_pkg::POLICY_W-1:0]    r_policy;
    logic [drs_pkg::DSIZE_W-1:0]     r_disk_size;
    drs_pkg::t_in_item               r_in;
    drs_pkg::t_out_item              r_out;

    // read pipeline
    logic [CNT_W-1:0] r_ptr;
    logic             r_dvld;
    logic [IDX_W-1:0] r_rd_pos;
    logic [BW-1:0]    r_rd_blk;
    logic [TW-1:0]    r_rd_tag;

    // trackers: a is the policy winner, b the lowest block for c-scan
    logic             r_found_a;
    logic [BW-1:0]    r_key_a, r_blk_a, r_key_b, r_blk_b;
    logic [TW-1:0]    r_tag_a, r_tag_b;
    logic [IDX_W-1:0] r_pos_a, r_pos_b;

    // chosen request
    logic [drs_pkg::STATUS_W-1:0] r_status;
    logic [BW-1:0]                r_sel_blk;
    logic [TW-1:0]                r_sel_tag;
    logic [BW-1:0]                r_seek;

    logic             rd_more, first, take_a, take_b, use_b, full;
    logic [BW-1:0]    diff, key_a, pick_blk;
    logic [TW-1:0]    pick_tag;
    logic [IDX_W-1:0] pick_pos;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [BW-1:0]    wr_blk;
    logic [TW-1:0]    wr_tag;
    logic [drs_pkg::TOTAL_W:0]   sum;
    logic [drs_pkg::DSIZE_W-1:0] last_blk;

    assign rd_more = (r_ptr < r_count);
    assign full    = (r_count >= CNT_W'(QUEUE_DEPTH));
    assign first   = (r_rd_pos == '0);
    assign diff    = (r_rd_blk >= r_head) ? (r_rd_blk - r_head) : (r_head - r_rd_blk);

    assign o_stat.is_dispatch = (r_in.req_type == drs_pkg::REQ_DISPATCH);
    assign o_stat.count_zero  = (r_count == '0);
    assign o_stat.scan_done   = !rd_more && !r_dvld;
    assign o_stat.shift_done  = !rd_more && !r_dvld;

    always_comb begin
        key_a  = r_rd_blk;
        take_a = first;
        case (r_policy)
            drs_pkg::POL_SSTF: begin
                key_a  = diff;
                take_a = first || (diff < r_key_a);
            end
            drs_pkg::POL_CSCAN: begin
                take_a = (r_rd_blk >= r_head) && (!r_found_a || (r_rd_blk < r_key_a));
            end
            default: begin
                take_a = first;
            end
        endcase
        take_b = (r_policy == drs_pkg::POL_CSCAN) && (first || (r_rd_blk < r_key_b));
    end

    assign use_b    = (r_policy == drs_pkg::POL_CSCAN) && !r_found_a;
    assign pick_blk = use_b ? r_blk_b : r_blk_a;
    assign pick_tag = use_b ? r_tag_b : r_tag_a;
    assign pick_pos = use_b ? r_pos_b : r_pos_a;

    // one write port shared by append and compaction
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_W-1:0];
        wr_blk  = r_in.block_number;
        wr_tag  = r_in.requester_tag;
        if (i_cmd.enq && !full) begin
            wr_en = 1'b1;
        end else if (i_cmd.shift && r_dvld) begin
            wr_en   = 1'b1;
            wr_addr = r_rd_pos - 1'b1;
            wr_blk  = r_rd_blk;
            wr_tag  = r_rd_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_blk[wr_addr] <= wr_blk;
            mem_tag[wr_addr] <= wr_tag;
        end
        if ((i_cmd.scan || i_cmd.shift) && rd_more) begin
            r_rd_blk <= mem_blk[r_ptr[IDX_W-1:0]];
            r_rd_tag <= mem_tag[r_ptr[IDX_W-1:0]];
            r_rd_pos <= r_ptr[IDX_W-1:0];
        end
    end

    assign sum      = {1'b0, r_total} + (drs_pkg::TOTAL_W + 1)'(r_seek);
    assign last_blk = r_disk_size - 1'b1;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_head      <= '0;
            r_total     <= '0;
            r_policy    <= drs_pkg::POL_FCFS;
            r_disk_size <= drs_pkg::DISK_SIZE_RST;
            r_ptr       <= '0;
            r_dvld      <= 1'b0;
            r_found_a   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == drs_pkg::CFG_POLICY) begin
                    r_policy <= i_cfg_data[drs_pkg::POLICY_W-1:0];
                end else if (i_cfg_index == drs_pkg::CFG_DISK_SIZE) begin
                    r_disk_size <= i_cfg_data;
                end
            end
            if (i_cmd.enq && !full) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.scan_start) begin
                r_ptr     <= '0;
                r_dvld    <= 1'b0;
                r_found_a <= 1'b0;
            end
            if (i_cmd.scan || i_cmd.shift) begin
                r_dvld <= rd_more;
                if (rd_more) begin
                    r_ptr <= r_ptr + 1'b1;
                end
            end
            if (i_cmd.scan && r_dvld && take_a) begin
                r_found_a <= 1'b1;
            end
            if (i_cmd.pick) begin
                r_ptr  <= CNT_W'(pick_pos) + 1'b1;
                r_dvld <= 1'b0;
            end
            if (i_cmd.fin) begin
                r_count <= r_count - 1'b1;
                r_total <= sum[drs_pkg::TOTAL_W] ? '1 : sum[drs_pkg::TOTAL_W-1:0];
                // wrap when landing on the last block
                if (r_disk_size != '0 && {1'b0, r_sel_blk} == last_blk) begin
                    r_head <= '0;
                end else begin
                    r_head <= r_sel_blk;
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_in <= i_in_item;
        end
        if (i_cmd.scan && r_dvld) begin
            if (take_a) begin
                r_key_a <= key_a;
                r_blk_a <= r_rd_blk;
                r_tag_a <= r_rd_tag;
                r_pos_a <= r_rd_pos;
            end
            if (take_b) begin
                r_key_b <= r_rd_blk;
                r_blk_b <= r_rd_blk;
                r_tag_b <= r_rd_tag;
                r_pos_b <= r_rd_pos;
            end
        end
        if (i_cmd.enq || i_cmd.empty) begin
            r_sel_blk <= '0;
            r_sel_tag <= '0;
            r_seek    <= '0;
            if (i_cmd.empty) begin
                r_status <= drs_pkg::ST_EMPTY;
            end else if (full) begin
                r_status <= drs_pkg::ST_REJECTED;
            end else begin
                r_status <= drs_pkg::ST_ENQUEUED;
            end
        end
        if (i_cmd.pick) begin
            r_sel_blk <= pick_blk;
            r_sel_tag <= pick_tag;
            r_seek    <= (pick_blk >= r_head) ? (pick_blk - r_head) : (r_head - pick_blk);
            r_status  <= drs_pkg::ST_DISPATCHED;
        end
        if (i_cmd.load_out) begin
            r_out.status         <= r_status;
            r_out.served_block   <= r_sel_blk;
            r_out.served_tag     <= r_sel_tag;
            r_out.seek_distance  <= r_seek;
            r_out.total_distance <= r_total;
            r_out.pending_count  <= drs_pkg::PEND_W'(r_count);
        end
    end

    assign o_out_item = r_out;

endmodule

// ===== rtl/disk_request_scheduler_unit.sv =====
// top level of the disk request scheduler: controller, datapath and checks
// enqueue and empty dispatch: the input beat is latched, then the decode and done states load the result
// dispatch: scan the n pending entries, pick, shift the entries behind the chosen slot down,
//   then finish and load the result; one memory entry per cycle in scan and compaction
// one item at a time; next beat taken the cycle after the result is loaded
// synchronous active-low reset empties the queue, zeroes head and total, fcfs, 65536 blocks
module disk_request_scheduler_unit #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  drs_pkg::t_in_item             i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output drs_pkg::t_out_item            o_out_item,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [drs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [drs_pkg::DSIZE_W-1:0]   i_cfg_data
);

    drs_pkg::t_dp_cmd  cmd;
    drs_pkg::t_dp_stat stat;

    // config writes are registered directly, never stalled
    assign o_cfg_ready = 1'b1;

    // sequencer: decode, scan, compact, finish, hand result to output register
    drs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // queue memory, scan trackers, head and seek total
    drs_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

    // one item in flight: no new beat right after one is taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input beat taken while previous item in flight");

    // a rejected enqueue only happens with a full queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == drs_pkg::ST_REJECTED) |->
        (o_out_item.pending_count == drs_pkg::PEND_W'(QUEUE_DEPTH)))
        else $error("rejected beat with room in queue");

    // empty dispatch reports nothing served
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == drs_pkg::ST_EMPTY) |->
        (o_out_item.pending_count == '0 && o_out_item.seek_distance == '0))
        else $error("empty dispatch with pending work or seek");

    // scan and compaction never run together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.scan && cmd.shift))
        else $error("scan and compaction overlap");

endmodule
